FILE: hw/rtl/mp2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mp2_pkg;

  // Fixed field widths of the result beat and of the configuration port.
  localparam int unsigned ROW_BITS          = 11;
  localparam int unsigned COL_BITS          = 9;
  localparam int unsigned BROW_BITS         = 10;
  localparam int unsigned CFG_DATA_BITS     = 11;
  localparam int unsigned MAX_POOLED_HEIGHT = 1024;

  // Configuration register indexes.
  localparam logic REG_POOLED_WIDTH  = 1'b0;
  localparam logic REG_POOLED_HEIGHT = 1'b1;

  // Input function codes.
  localparam logic FUNC_FWD = 1'b0;
  localparam logic FUNC_BWD = 1'b1;

  // Result kind codes.
  localparam logic KIND_POOLED = 1'b0;
  localparam logic KIND_GRAD   = 1'b1;

  typedef struct packed {
    logic                     we;
    logic                     idx;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic                kind;
    logic [1:0]          pick;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                eop;
  } res_meta_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mp2_fwd.sv
`timescale 1ns / 1ps
`default_nettype none

module mp2_fwd import mp2_pkg::*; #(
  parameter int unsigned MAX_POOLED_WIDTH = 256,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_wr_t                       cfg_i,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          hit_o,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output res_meta_t                     meta_o
);

  localparam int unsigned WMAX  = (MAX_POOLED_WIDTH < 511) ? MAX_POOLED_WIDTH : 511;
  localparam int unsigned BCW   = (WMAX > 1) ? $clog2(WMAX) : 1;
  localparam int unsigned WB    = BCW + 1;
  localparam int unsigned FCW   = ($clog2(2 * WMAX) > 2) ? $clog2(2 * WMAX) : 2;
  localparam int unsigned IW    = FCW - 1;
  localparam int unsigned DEPTH = MAX_POOLED_WIDTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [FCW-1:0]               fcol_last_q;
  logic [ROW_BITS-1:0]          frow_last_q;
  logic [FCW-1:0]               col_q;
  logic [ROW_BITS-1:0]          row_q;
  logic signed [SAMPLE_BITS-1:0] left_q;
  logic [SAMPLE_BITS:0]         rd_q;
  logic [SAMPLE_BITS:0]         mem [DEPTH];

  logic [COL_BITS-1:0]          w_raw;
  logic [WB-1:0]                w_eff;
  logic [ROW_BITS-1:0]          h_eff;
  logic [IW-1:0]                idx;
  logic [AW-1:0]                addr;
  logic                         odd_col;
  logic                         bottom_row;
  logic                         pair_b;
  logic signed [SAMPLE_BITS-1:0] pair_v;
  logic signed [SAMPLE_BITS-1:0] top_v;
  logic                         top_b;
  logic                         col_wrap;

  always_comb begin
    w_raw = cfg_i.data[COL_BITS-1:0];
    if (w_raw == '0) begin
      w_eff = WB'(1);
    end else if (w_raw > COL_BITS'(WMAX)) begin
      w_eff = WB'(WMAX);
    end else begin
      w_eff = WB'(w_raw);
    end
    if (cfg_i.data == '0) begin
      h_eff = ROW_BITS'(1);
    end else if (cfg_i.data > CFG_DATA_BITS'(MAX_POOLED_HEIGHT)) begin
      h_eff = ROW_BITS'(MAX_POOLED_HEIGHT);
    end else begin
      h_eff = ROW_BITS'(cfg_i.data);
    end
  end

  assign idx        = col_q[FCW-1:1];
  assign addr       = AW'(idx);
  assign odd_col    = col_q[0];
  assign bottom_row = row_q[0];
  assign col_wrap   = (col_q == fcol_last_q);

  // Best of the horizontal pair; the left pixel wins a tie.
  assign pair_b = (sample_i > left_q);
  assign pair_v = pair_b ? sample_i : left_q;
  assign top_v  = $signed(rd_q[SAMPLE_BITS-1:0]);
  assign top_b  = rd_q[SAMPLE_BITS];

  always_comb begin
    hit_o       = en_i && odd_col && bottom_row;
    meta_o.kind = KIND_POOLED;
    if (pair_v > top_v) begin
      value_o     = pair_v;
      meta_o.pick = {1'b1, pair_b};
    end else begin
      value_o     = top_v;
      meta_o.pick = {1'b0, top_b};
    end
    meta_o.row = ROW_BITS'(row_q[ROW_BITS-1:1]);
    meta_o.col = COL_BITS'(idx);
    meta_o.eop = (row_q == frow_last_q) && col_wrap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcol_last_q <= FCW'(1);
      frow_last_q <= ROW_BITS'(1);
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        REG_POOLED_WIDTH:  fcol_last_q <= FCW'({w_eff, 1'b0} - 1'b1);
        REG_POOLED_HEIGHT: frow_last_q <= ROW_BITS'({h_eff, 1'b0} - 1'b1);
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (en_i) begin
      if (!odd_col) begin
        left_q <= sample_i;
      end
      if (col_wrap) begin
        col_q <= '0;
        row_q <= (row_q == frow_last_q) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Line buffer: the top row writes each pair's best, the bottom row reads
  // it back one pixel early so the data is registered by the odd pixel.
  always_ff @(posedge clk_i) begin
    if (en_i && odd_col && !bottom_row) begin
      mem[addr] <= {pair_b, pair_v};
    end
    if (en_i && !odd_col && bottom_row) begin
      rd_q <= mem[addr];
    end
  end

`ifndef ASSERT_OFF
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= fcol_last_q) else $error("forward column beyond row end");
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= frow_last_q) else $error("forward row beyond plane end");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/mp2_bwd.sv
`timescale 1ns / 1ps
`default_nettype none

module mp2_bwd import mp2_pkg::*; #(
  parameter int unsigned MAX_POOLED_WIDTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_wr_t    cfg_i,
  input  logic       en_i,
  input  logic [1:0] pick_i,
  output res_meta_t  meta_o
);

  localparam int unsigned WMAX = (MAX_POOLED_WIDTH < 511) ? MAX_POOLED_WIDTH : 511;
  localparam int unsigned BCW  = (WMAX > 1) ? $clog2(WMAX) : 1;
  localparam int unsigned WB   = BCW + 1;

  logic [BCW-1:0]       bcol_last_q;
  logic [BROW_BITS-1:0] brow_last_q;
  logic [BCW-1:0]       col_q;
  logic [BROW_BITS-1:0] row_q;

  logic [COL_BITS-1:0]  w_raw;
  logic [WB-1:0]        w_eff;
  logic [ROW_BITS-1:0]  h_eff;
  logic                 col_wrap;
  logic                 row_wrap;

  always_comb begin
    w_raw = cfg_i.data[COL_BITS-1:0];
    if (w_raw == '0) begin
      w_eff = WB'(1);
    end else if (w_raw > COL_BITS'(WMAX)) begin
      w_eff = WB'(WMAX);
    end else begin
      w_eff = WB'(w_raw);
    end
    if (cfg_i.data == '0) begin
      h_eff = ROW_BITS'(1);
    end else if (cfg_i.data > CFG_DATA_BITS'(MAX_POOLED_HEIGHT)) begin
      h_eff = ROW_BITS'(MAX_POOLED_HEIGHT);
    end else begin
      h_eff = ROW_BITS'(cfg_i.data);
    end
  end

  assign col_wrap = (col_q == bcol_last_q);
  assign row_wrap = (row_q == brow_last_q);

  // The gradient lands on the input pixel picked in the forward pass.
  always_comb begin
    meta_o.kind = KIND_GRAD;
    meta_o.pick = pick_i;
    meta_o.row  = {row_q, pick_i[1]};
    meta_o.col  = COL_BITS'({col_q, pick_i[0]});
    meta_o.eop  = row_wrap && col_wrap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcol_last_q <= '0;
      brow_last_q <= '0;
      col_q       <= '0;
      row_q       <= '0;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        REG_POOLED_WIDTH:  bcol_last_q <= BCW'(w_eff - 1'b1);
        REG_POOLED_HEIGHT: brow_last_q <= BROW_BITS'(h_eff - 1'b1);
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (en_i) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= bcol_last_q) && (row_q <= brow_last_q))
    else $error("backward position beyond plane end");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/mp2_out.sv
`timescale 1ns / 1ps
`default_nettype none

module mp2_out import mp2_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic signed [SAMPLE_BITS-1:0] value_i,
  input  res_meta_t                     meta_i,
  input  logic                          out_ready_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output res_meta_t                     meta_o
);

  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] value_q;
  res_meta_t                     meta_q;

  // The register may take a new beat in the cycle its old one leaves.
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign value_o     = value_q;
  assign meta_o      = meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q <= value_i;
      meta_q  <= meta_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o) else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/max_pool_2x2_stride2_unit.sv
// Output: a result beat is valid in the cycle after the input beat that completes it.
// Throughput: one input beat per cycle, forward and backward alike, while the
// output register drains; the line buffer takes one access per horizontal pixel pair.
// Reset: asynchronous, active low; counters clear, both sizes return to 1, and
// the line buffer needs no clearing since each entry is written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module max_pool_2x2_stride2_unit import mp2_pkg::*; #(
  parameter int unsigned MAX_POOLED_WIDTH = 256,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [1:0]                    pick_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic signed [SAMPLE_BITS-1:0] result_value_o,
  output logic [1:0]                    best_pick_o,
  output logic [ROW_BITS-1:0]           row_o,
  output logic [COL_BITS-1:0]           col_o,
  output logic                          end_of_plane_o
);

  // A configuration write goes to both position trackers at once; each keeps
  // its own copy of the limits it compares against.
  cfg_wr_t cfg;
  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_index_i;
  assign cfg.data = cfg_wdata_i;

  logic                          accept;
  logic                          fwd_en;
  logic                          bwd_en;
  logic                          fwd_hit;
  logic signed [SAMPLE_BITS-1:0] fwd_value;
  res_meta_t                     fwd_meta;
  res_meta_t                     bwd_meta;
  logic                          load;
  logic signed [SAMPLE_BITS-1:0] res_value;
  res_meta_t                     res_meta;
  res_meta_t                     out_meta;
  logic                          out_free;

  // An input beat is taken whenever the output register is empty or is being
  // emptied in this cycle, so the stream runs at one beat per cycle.
  assign in_ready_o = out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign fwd_en     = accept && (func_i == FUNC_FWD);
  assign bwd_en     = accept && (func_i == FUNC_BWD);

  mp2_fwd #(
    .MAX_POOLED_WIDTH(MAX_POOLED_WIDTH),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .en_i    (fwd_en),
    .sample_i(sample_i),
    .hit_o   (fwd_hit),
    .value_o (fwd_value),
    .meta_o  (fwd_meta)
  );

  mp2_bwd #(
    .MAX_POOLED_WIDTH(MAX_POOLED_WIDTH)
  ) u_bwd (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .en_i  (bwd_en),
    .pick_i(pick_in_i),
    .meta_o(bwd_meta)
  );

  // Forward beats produce a result only on a window's bottom-right pixel;
  // every backward beat produces one, with the gradient passed through.
  assign load      = bwd_en || fwd_hit;
  assign res_value = (func_i == FUNC_BWD) ? sample_i : fwd_value;
  assign res_meta  = (func_i == FUNC_BWD) ? bwd_meta : fwd_meta;

  mp2_out #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .value_i    (res_value),
    .meta_i     (res_meta),
    .out_ready_i(out_ready_i),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .value_o    (result_value_o),
    .meta_o     (out_meta)
  );

  assign kind_o         = out_meta.kind;
  assign best_pick_o    = out_meta.pick;
  assign row_o          = out_meta.row;
  assign col_o          = out_meta.col;
  assign end_of_plane_o = out_meta.eop;

`ifndef ASSERT_OFF
  a_bwd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bwd_en |=> (out_valid_o && (kind_o == KIND_GRAD)))
    else $error("backward beat did not produce a gradient result");
`endif

endmodule

`default_nettype wire
